// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rasterizer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ALR_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rasterizer check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ALR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rasterizer check failed");

`endif

// ===== rtl/alr_pkg.sv =====
// Shared types and constants for the antialiased line rasterizer.
// No dependencies; imported by every rasterizer module.
package alr_pkg;

    // Item actions
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_LINE   = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // Configuration register index (paddr bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Plot coordinate sources
    localparam logic [1:0] PSRC_PIXEL = 2'd0;
    localparam logic [1:0] PSRC_SOLID = 2'd1;
    localparam logic [1:0] PSRC_WU    = 2'd2;

    // Solid run x direction
    localparam logic [1:0] DIR_HOLD = 2'd0;
    localparam logic [1:0] DIR_INC  = 2'd1;
    localparam logic [1:0] DIR_DEC  = 2'd2;

    localparam int COORD_W = 10;      // signed plot coordinate
    localparam int DIM_W   = 13;      // frame dimension, covers 4096
    localparam logic [16:0] ACC_LIMIT  = 17'h0ffff;
    localparam logic [7:0]  ALPHA_FULL = 8'hff;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic       latch_in;
        logic       line_setup;
        logic       step_load;
        logic [1:0] plot_src;
        logic [1:0] plot_idx;
        logic       addr_calc;
        logic       clip_en;
        logic       mem_rd;
        logic       mem_wr;
        logic       wr_mix;
        logic       mix;
        logic       solid_adv;
        logic       wu_adv;
        logic       out_load;
        logic       out_line;
    } alr_cmd_t;

    typedef struct packed {
        logic is_wu;
        logic div_done;
        logic solid_last;
        logic wu_done;
        logic plot_skip;
        logic plot_in;
        logic plot_full;
        logic out_free;
    } alr_status_t;

endpackage

// ===== rtl/alr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Wu error step.
// Depends on alr_pkg.
module alr_div
    import alr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] num,
    input  logic [7:0]  den,
    output logic        done,
    output logic [15:0] quot
);

    logic [7:0]  rem_reg, rem_next;
    logic [23:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;
    logic        fits;

    // Load the operands on start, otherwise one shift-subtract step while busy
    always_comb begin
        trial     = {rem_reg, quo_reg[23]};
        fits      = trial >= {1'b0, den};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 8'(trial - {1'b0, den}) : trial[7:0];
            quo_next = {quo_reg[22:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg[15:0];

endmodule

// ===== rtl/alr_ctrl.sv =====
// Controller state machine: sequences pixel access, solid runs and Wu walks.
// Depends on alr_pkg; drives the datapath through alr_cmd_t.
module alr_ctrl
    import alr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic [1:0]  s_action,
    output logic        s_ready,
    input  alr_status_t status,
    output alr_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_WU_CHK = 4'd3;
    localparam logic [3:0] S_ADDR   = 4'd4;
    localparam logic [3:0] S_ACCESS = 4'd5;
    localparam logic [3:0] S_MIX    = 4'd6;
    localparam logic [3:0] S_WRITE  = 4'd7;
    localparam logic [3:0] S_NEXT   = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] act_reg, act_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        act_next   = act_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    act_next     = s_action;
                    if (s_action == ACT_WRITE || s_action == ACT_READ) begin
                        mode_next  = PSRC_PIXEL;
                        state_next = S_ADDR;
                    end else if (s_action == ACT_LINE) begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                cmd.line_setup = 1'b1;
                if (status.is_wu) begin
                    mode_next  = PSRC_WU;
                    state_next = S_DIV;
                end else begin
                    mode_next  = PSRC_SOLID;
                    state_next = S_ADDR;
                end
            end
            S_DIV: begin
                if (status.div_done) begin
                    cmd.step_load = 1'b1;
                    state_next    = S_WU_CHK;
                end
            end
            S_WU_CHK: begin
                idx_next   = 2'd0;
                state_next = status.wu_done ? S_RESULT : S_ADDR;
            end
            S_ADDR: begin
                cmd.addr_calc = 1'b1;
                cmd.plot_src  = mode_reg;
                cmd.plot_idx  = idx_reg;
                cmd.clip_en   = mode_reg != PSRC_PIXEL;
                state_next    = S_ACCESS;
            end
            S_ACCESS: begin
                priority if (mode_reg == PSRC_PIXEL) begin
                    if (act_reg == ACT_READ) begin
                        cmd.mem_rd = 1'b1;
                        state_next = S_RESULT;
                    end else begin
                        cmd.mem_wr = status.plot_in;
                        state_next = S_IDLE;
                    end
                end else if (status.plot_skip || !status.plot_in) begin
                    state_next = S_NEXT;
                end else if (status.plot_full) begin
                    cmd.mem_wr = 1'b1;
                    state_next = S_NEXT;
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_MIX;
                end
            end
            S_MIX: begin
                cmd.mix    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                cmd.mem_wr = 1'b1;
                cmd.wr_mix = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (mode_reg == PSRC_SOLID) begin
                    if (status.solid_last) begin
                        state_next = S_RESULT;
                    end else begin
                        cmd.solid_adv = 1'b1;
                        state_next    = S_ADDR;
                    end
                end else if (idx_reg == 2'd3) begin
                    cmd.wu_adv = 1'b1;
                    state_next = S_WU_CHK;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_ADDR;
                end
            end
            S_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_line = mode_reg != PSRC_PIXEL;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= PSRC_PIXEL;
            idx_reg   <= '0;
            act_reg   <= ACT_WRITE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            act_reg   <= act_next;
        end
    end

endmodule

// ===== rtl/alr_datapath.sv =====
// Datapath: line setup, Wu and solid cursors, plot addressing, blend and frame store.
// Depends on alr_pkg and alr_div; commanded by alr_ctrl.
module alr_datapath
    import alr_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  alr_cmd_t          cmd,
    output alr_status_t       status,
    input  logic [7:0]        s_x_start,
    input  logic [7:0]        s_y_start,
    input  logic [7:0]        s_x_end,
    input  logic [7:0]        s_y_end,
    input  logic [23:0]       s_color,
    input  logic [DIM_W-1:0]  w_eff,
    input  logic [DIM_W-1:0]  h_eff,
    input  logic              m_ready,
    output logic              m_valid,
    output logic              m_kind,
    output logic [23:0]       m_read_color,
    output logic              m_clipped
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // Latched item
    logic [7:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic [23:0] color_reg;

    // Solid run
    logic [7:0] sol_x_reg, sol_y_reg;
    logic [1:0] sol_xdir_reg;
    logic       sol_yinc_reg;
    logic [8:0] sol_cnt_reg;

    // Wu walk
    coord_t      near_reg, far_reg, nmin_reg, fmin_reg;
    logic        sneg_reg, xmaj_reg;
    logic [16:0] acc_reg;
    logic [15:0] step_reg;

    // Plot stage
    logic [AW-1:0] addr_reg;
    logic [7:0]    alpha_reg;
    logic          in_reg;
    logic          clip_reg;
    logic [15:0]   mix_reg [3];
    logic [23:0]   rdata_reg;

    logic [23:0] mem [DEPTH];

    // Output register
    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [23:0] m_color_reg;
    logic        m_clip_reg;

    // Line classification
    logic [7:0] dx, dy, dmin_abs, dmaj;
    logic       y_up, x_up, xmaj, is_wu;
    logic [7:0] ax, ay, bx, by;
    logic [23:0] div_num;
    logic        div_done;
    logic [15:0] div_quot;

    always_comb begin
        x_up     = x1_reg > x0_reg;
        y_up     = y1_reg > y0_reg;
        dx       = x_up ? x1_reg - x0_reg : x0_reg - x1_reg;
        dy       = y_up ? y1_reg - y0_reg : y0_reg - y1_reg;
        is_wu    = (dx != 8'd0) && (dy != 8'd0) && (dx != dy);
        xmaj     = dx > dy;
        // start point has the smaller major coordinate
        if ((xmaj && x0_reg < x1_reg) || (!xmaj && y0_reg < y1_reg)) begin
            ax = x0_reg; ay = y0_reg; bx = x1_reg; by = y1_reg;
        end else begin
            ax = x1_reg; ay = y1_reg; bx = x0_reg; by = y0_reg;
        end
        dmin_abs = xmaj ? dy : dx;
        dmaj     = xmaj ? dx : dy;
        div_num  = {dmin_abs, 16'h0000} - 24'(dmin_abs);
    end

    alr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.line_setup && is_wu),
        .num     (div_num),
        .den     (dmaj),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Plot coordinate and alpha selection
    logic [7:0]  wu_i;
    coord_t      maj_c, min_c, px, py;
    logic [7:0]  palpha;
    logic        p_in;
    logic [2*DIM_W-1:0] lin;

    always_comb begin
        wu_i  = acc_reg[15:8];
        maj_c = cmd.plot_idx[1] ? far_reg : near_reg;
        unique case (cmd.plot_idx)
            2'd0:    min_c = nmin_reg;
            2'd1:    min_c = sneg_reg ? nmin_reg - coord_t'(1) : nmin_reg + coord_t'(1);
            2'd2:    min_c = fmin_reg;
            default: min_c = sneg_reg ? fmin_reg + coord_t'(1) : fmin_reg - coord_t'(1);
        endcase
        unique case (cmd.plot_src)
            PSRC_SOLID: begin
                px     = coord_t'({2'b00, sol_x_reg});
                py     = coord_t'({2'b00, sol_y_reg});
                palpha = ALPHA_FULL;
            end
            PSRC_WU: begin
                px     = xmaj_reg ? maj_c : min_c;
                py     = xmaj_reg ? min_c : maj_c;
                palpha = cmd.plot_idx[0] ? wu_i : ALPHA_FULL - wu_i;
            end
            default: begin
                px     = coord_t'({2'b00, x0_reg});
                py     = coord_t'({2'b00, y0_reg});
                palpha = ALPHA_FULL;
            end
        endcase
        p_in = !px[COORD_W-1] && !py[COORD_W-1]
            && (DIM_W'(px[COORD_W-2:0]) < w_eff)
            && (DIM_W'(py[COORD_W-2:0]) < h_eff);
        lin  = (2*DIM_W)'(py[COORD_W-2:0]) * (2*DIM_W)'(w_eff)
             + (2*DIM_W)'(px[COORD_W-2:0]);
    end

    // Blend: divide each channel sum by 255 (exact for sums up to 255 * 255)
    logic [23:0] mix_color;
    logic [16:0] mix_q [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mix_q[k] = 17'(mix_reg[k]) + 17'(mix_reg[k][15:8]) + 17'd1;
            mix_color[8*k +: 8] = mix_q[k][15:8];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            step_reg    <= '0;
            near_reg    <= '0;
            far_reg     <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.line_setup) begin
                acc_reg  <= '0;
                clip_reg <= 1'b0;
                near_reg <= coord_t'({2'b00, xmaj ? ax : ay});
                far_reg  <= coord_t'({2'b00, xmaj ? bx : by});
            end else if (cmd.wu_adv) begin
                near_reg <= near_reg + coord_t'(1);
                far_reg  <= far_reg - coord_t'(1);
                if (acc_reg + 17'(step_reg) > ACC_LIMIT) begin
                    acc_reg <= acc_reg + 17'(step_reg) - ACC_LIMIT;
                end else begin
                    acc_reg <= acc_reg + 17'(step_reg);
                end
            end
            if (cmd.step_load) begin
                step_reg <= div_quot;
            end
            if (cmd.addr_calc && cmd.clip_en && palpha != 8'd0 && !p_in) begin
                clip_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            x0_reg    <= s_x_start;
            y0_reg    <= s_y_start;
            x1_reg    <= s_x_end;
            y1_reg    <= s_y_end;
            color_reg <= s_color;
        end
        if (cmd.line_setup) begin
            // solid run setup
            if (dx == 8'd0) begin
                sol_x_reg    <= x0_reg;
                sol_y_reg    <= y_up ? y0_reg : y1_reg;
                sol_xdir_reg <= DIR_HOLD;
                sol_yinc_reg <= 1'b1;
                sol_cnt_reg  <= 9'(dy) + 9'd1;
            end else if (dy == 8'd0) begin
                sol_x_reg    <= x_up ? x0_reg : x1_reg;
                sol_y_reg    <= y0_reg;
                sol_xdir_reg <= DIR_INC;
                sol_yinc_reg <= 1'b0;
                sol_cnt_reg  <= 9'(dx);
            end else begin
                sol_x_reg    <= y_up ? x0_reg : x1_reg;
                sol_y_reg    <= y_up ? y0_reg : y1_reg;
                sol_xdir_reg <= (x_up == y_up) ? DIR_INC : DIR_DEC;
                sol_yinc_reg <= 1'b1;
                sol_cnt_reg  <= 9'(dx) + 9'd1;
            end
            // Wu setup
            xmaj_reg <= xmaj;
            nmin_reg <= coord_t'({2'b00, xmaj ? ay : ax});
            fmin_reg <= coord_t'({2'b00, xmaj ? by : bx});
            sneg_reg <= xmaj ? (by < ay) : (bx < ax);
        end else if (cmd.solid_adv) begin
            sol_cnt_reg <= sol_cnt_reg - 9'd1;
            if (sol_yinc_reg) begin
                sol_y_reg <= sol_y_reg + 8'd1;
            end
            if (sol_xdir_reg == DIR_INC) begin
                sol_x_reg <= sol_x_reg + 8'd1;
            end else if (sol_xdir_reg == DIR_DEC) begin
                sol_x_reg <= sol_x_reg - 8'd1;
            end
        end else if (cmd.wu_adv && (acc_reg + 17'(step_reg) > ACC_LIMIT)) begin
            nmin_reg <= sneg_reg ? nmin_reg - coord_t'(1) : nmin_reg + coord_t'(1);
            fmin_reg <= sneg_reg ? fmin_reg + coord_t'(1) : fmin_reg - coord_t'(1);
        end
        if (cmd.addr_calc) begin
            addr_reg  <= lin[AW-1:0];
            alpha_reg <= palpha;
            in_reg    <= p_in;
        end
        if (cmd.mix) begin
            for (int k = 0; k < 3; k++) begin
                mix_reg[k] <= 16'(rdata_reg[8*k +: 8]) * 16'(ALPHA_FULL - alpha_reg)
                            + 16'(color_reg[8*k +: 8]) * 16'(alpha_reg);
            end
        end
        if (cmd.out_load) begin
            m_kind_reg  <= cmd.out_line ? KIND_LINE : KIND_READ;
            m_color_reg <= (!cmd.out_line && in_reg) ? rdata_reg : 24'h0;
            m_clip_reg  <= cmd.out_line ? clip_reg : !in_reg;
        end
    end

    // Frame store
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[addr_reg] <= cmd.wr_mix ? mix_color : color_reg;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_comb begin
        status.is_wu      = is_wu;
        status.div_done   = div_done;
        status.solid_last = sol_cnt_reg == 9'd1;
        status.wu_done    = far_reg < near_reg;
        status.plot_skip  = alpha_reg == 8'd0;
        status.plot_in    = in_reg;
        status.plot_full  = alpha_reg == ALPHA_FULL;
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_read_color = m_color_reg;
    assign m_clipped    = m_clip_reg;

endmodule

// ===== rtl/antialiased_line_rasterizer.sv =====
// Pixel write: address registered in S_ADDR, store written from S_ACCESS, then back to idle.
// Pixel read: S_ADDR, S_ACCESS, then S_RESULT loads the output. Solid line: setup, then per plot
// S_ADDR, S_ACCESS, S_NEXT. Wu line: setup waits on the 24-step divider, then per step of the walk
// 4 plots of S_ADDR, S_ACCESS, S_MIX and S_WRITE when blended, S_NEXT. One item at a time.
// aresetn (sync, low) clears control state; frame size resets to 256 x 256; frame store
// contents are undefined until written.
`include "assert_macros.svh"

module antialiased_line_rasterizer
    import alr_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_x_start,
    input  logic [7:0]  s_y_start,
    input  logic [7:0]  s_x_end,
    input  logic [7:0]  s_y_end,
    input  logic [23:0] s_color,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [23:0] m_read_color,
    output logic        m_clipped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0]       fw_reg, fh_reg;
    logic [DIM_W-1:0] w_eff, h_eff;
    alr_cmd_t         cmd;
    alr_status_t      status;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 9'd256;
            fh_reg <= 9'd256;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HEIGHT) begin
                fh_reg <= pwdata[8:0];
            end else begin
                fw_reg <= pwdata[8:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WIDTH) ? 32'(fw_reg) : 32'(fh_reg);

    // Usable frame is clamped to the store size
    assign w_eff = (DIM_W'(fw_reg) < DIM_W'(MAX_WIDTH))  ? DIM_W'(fw_reg) : DIM_W'(MAX_WIDTH);
    assign h_eff = (DIM_W'(fh_reg) < DIM_W'(MAX_HEIGHT)) ? DIM_W'(fh_reg) : DIM_W'(MAX_HEIGHT);

    alr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    alr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_x_start    (s_x_start),
        .s_y_start    (s_y_start),
        .s_x_end      (s_x_end),
        .s_y_end      (s_y_end),
        .s_color      (s_color),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_kind       (m_kind),
        .m_read_color (m_read_color),
        .m_clipped    (m_clipped)
    );

    // Line-done beats carry no color
    `ALR_ASSERT_IMPLIES(a_line_no_color, aclk, aresetn, m_valid && (m_kind == KIND_LINE), m_read_color == 24'h0)
    // A clipped read returns zero
    `ALR_ASSERT_IMPLIES(a_clip_read_zero, aclk, aresetn, m_valid && (m_kind == KIND_READ) && m_clipped, m_read_color == 24'h0)
    // A real item keeps the block busy for at least the following cycle
    `ALR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready && (s_action != ACT_IGNORE), !s_ready)

endmodule
